// ===== sv/pwb_pkg.sv =====
// ----------------------------------------------------------------------------
// pwb_pkg: shared types and constants
// Payload structs, register indexes and the fixed-point helpers that the
// particle integration pipeline uses.
// ----------------------------------------------------------------------------
`default_nettype none

package pwb_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic        [30:0] density_sum;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] wall_force_x;
        logic signed [31:0] wall_force_y;
        logic signed [31:0] wall_force_z;
        logic        [30:0] wall_density;
        logic signed [31:0] pressure;
        logic        [30:0] mass_over_density;
    } t_out;

    // side data that rides along the arithmetic stages
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] wf;
        logic [30:0]      wden;
        logic [31:0]      pres;
    } t_carry;

    // everything but the divider result
    typedef struct packed {
        logic [2:0][31:0] npos;
        logic [2:0][31:0] nvel;
        logic [2:0][31:0] wf;
        logic [30:0]      wden;
        logic [31:0]      pres;
    } t_main;

    localparam logic [1:0] CFG_BOX_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_MASS       = 2'd1;
    localparam logic [1:0] CFG_PRES_OFS   = 2'd2;

    // floor((f + 500) / 1000) is taken on a biased, non-negative value
    localparam logic signed [34:0] FORCE_BIAS   = 35'sd4194304500;
    localparam logic signed [47:0] FORCE_UNBIAS = 48'sd4194304;

    // reciprocals floor(2^32/125), floor(2^32/25), floor(2^33/5)
    localparam logic [25:0] R125 = 26'd34359738;
    localparam logic [27:0] R25  = 28'd171798691;
    localparam logic [30:0] R5   = 31'd1717986918;

    localparam logic signed [47:0] VEL_TO_POS = 48'sd35;

    // stages of the arithmetic path, input register included
    localparam int MAIN_STAGES = 17;

    function automatic logic signed [31:0] sat_s32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < 48'shFFFF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // floor((4r + 2) / 5) for a remainder 0..4
    function automatic logic [1:0] rnd_q5(input logic [2:0] r);
        logic [1:0] q;
        case (r)
            3'd0:    q = 2'd0;
            3'd1:    q = 2'd1;
            3'd2:    q = 2'd2;
            3'd3:    q = 2'd2;
            3'd4:    q = 2'd3;
            default: q = 2'd0;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pwb_div.sv =====
// ----------------------------------------------------------------------------
// pwb_div: pipelined restoring divider
// (mass << FRAC_BITS) / den, one quotient bit per stage, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [30:0] i_num,
    input  wire logic [31:0] i_den,
    output logic      [30:0] o_quot
);

    localparam int NW = 31 + FRAC_BITS;

    logic [31:0]   r_rem [NW];
    logic [31:0]   r_den [NW];
    logic [NW-1:0] r_num [NW];
    logic [30:0]   r_q   [NW];

    for (genvar j = 0; j < NW; j++) begin : g_st
        logic [31:0]   rem_in;
        logic [31:0]   den_in;
        logic [NW-1:0] num_in;
        logic [30:0]   q_in;
        logic [32:0]   sh;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = i_den;
            assign num_in = {i_num, {FRAC_BITS{1'b0}}};
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign num_in = r_num[j-1];
            assign q_in   = r_q[j-1];
        end

        assign sh = {rem_in, num_in[NW-1]};
        assign ge = (sh >= {1'b0, den_in});

        // quotient never exceeds 31 bits since den >= 1.0
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? 32'(sh - {1'b0, den_in}) : sh[31:0];
                r_den[j] <= den_in;
                r_num[j] <= {num_in[NW-2:0], 1'b0};
                r_q[j]   <= {q_in[29:0], ge};
            end
        end
    end

    assign o_quot = r_q[NW-1];

endmodule

`default_nettype wire

// ===== sv/particle_integrate_wall_bounce.sv =====
// ----------------------------------------------------------------------------
// particle_integrate_wall_bounce: fixed-point particle update with box walls
// One particle per cycle unless stalled: force kick, wall penalty, bounce/damping, advance.
// ----------------------------------------------------------------------------
// Usage: the block takes one particle per clock while o_in_stall is low and
// returns one result per particle, in order. The pipeline depth is set by
// the mass/density divider, which resolves one quotient bit per stage; the
// rest of the datapath (force scaling, wall terms, three bounce steps, final
// advance) is 17 stages and is delayed to match.
// The whole pipe advances together; o_in_stall is raised only while a result
// sits at the output and the consumer stalls it. Write the configuration
// registers only while no particle is in flight.
`default_nettype none

module particle_integrate_wall_bounce #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire pwb_pkg::t_in    i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output pwb_pkg::t_out        o_out_data,
    input  wire logic            i_out_stall,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data
);
    import pwb_pkg::*;

    localparam int LAST = 32 + FRAC_BITS;
    localparam int DLY  = LAST - MAIN_STAGES;

    // configuration
    logic [14:0]        r_box;
    logic [30:0]        r_mass;
    logic signed [31:0] r_pofs;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box  <= 15'd100;
            r_mass <= 31'd65536;
            r_pofs <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BOX_LIMIT: r_box  <= i_cfg_data[14:0];
                CFG_MASS:      r_mass <= i_cfg_data[30:0];
                CFG_PRES_OFS:  r_pofs <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // pipeline control
    logic          pipe_en;
    logic [LAST:1] r_vld;

    assign pipe_en     = !r_vld[LAST] || !i_out_stall;
    assign o_in_stall  = !pipe_en;
    assign o_out_valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAST-1:1], i_in_valid};
        end
    end

    // box geometry
    logic signed [41:0] one42;
    logic signed [41:0] lim;
    logic signed [41:0] hi;

    assign one42 = 42'sd1 <<< FRAC_BITS;
    assign lim   = $signed({27'd0, r_box}) <<< FRAC_BITS;
    assign hi    = lim - one42;

    // stage 1: input register
    t_in r_s1;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1 <= i_in_data;
        end
    end

    logic signed [31:0] s1_pos [3];
    logic signed [31:0] s1_vel [3];
    logic signed [31:0] s1_frc [3];

    assign s1_pos[0] = r_s1.pos_x;
    assign s1_pos[1] = r_s1.pos_y;
    assign s1_pos[2] = r_s1.pos_z;
    assign s1_vel[0] = r_s1.vel_x;
    assign s1_vel[1] = r_s1.vel_y;
    assign s1_vel[2] = r_s1.vel_z;
    assign s1_frc[0] = r_s1.force_x;
    assign s1_frc[1] = r_s1.force_y;
    assign s1_frc[2] = r_s1.force_z;

    // density, pressure
    logic [31:0]        dens;
    logic signed [31:0] n2_pres;

    assign dens    = 32'(r_s1.density_sum) + 32'(one42);
    assign n2_pres = sat_s32(48'(r_pofs) + 48'($signed({17'd0, dens[31:1]})));

    pwb_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_num  (r_mass),
        .i_den  (dens),
        .o_quot (o_out_data.mass_over_density)
    );

    // stage 2: biased force operand, wall depth
    logic [30:0]        n2_xf [3];
    logic [30:0]        n2_xw [3];
    logic signed [31:0] n2_wf [3];

    for (genvar a = 0; a < 3; a++) begin : g_s2
        logic signed [34:0] fb;
        logic signed [41:0] p42;
        logic signed [41:0] dep;
        logic signed [41:0] d50;
        logic               lo;
        logic               hw;

        assign fb  = 35'(s1_frc[a]) + FORCE_BIAS;
        assign p42 = 42'(s1_pos[a]);
        assign lo  = (p42 < one42);
        assign hw  = (p42 > hi);
        assign dep = lo ? (one42 - p42) : (p42 - hi);
        assign d50 = dep + 42'sd50;

        assign n2_xf[a] = fb[33:3];
        assign n2_xw[a] = (lo || hw) ? d50[32:2] : '0;
        assign n2_wf[a] = lo ? sat_s32(48'(dep)) :
                          hw ? sat_s32(-48'(dep)) : 32'sd0;
    end

    t_carry             r_cy [2:16];
    logic [30:0]        r2_xf  [3];
    logic [30:0]        r2_xw  [3];
    logic signed [31:0] r2_vel [3];
    logic [56:0]        r3_pf  [3];
    logic [58:0]        r3_pw  [3];
    logic [30:0]        r3_xf  [3];
    logic [30:0]        r3_xw  [3];
    logic signed [31:0] r3_vel [3];
    logic [26:0]        r4_qf  [3];
    logic [26:0]        r4_qw  [3];
    logic [30:0]        r4_xf  [3];
    logic [30:0]        r4_xw  [3];
    logic signed [31:0] r4_vel [3];
    logic [26:0]        r5_qf  [3];
    logic [26:0]        r5_qw  [3];
    logic signed [31:0] r5_vel [3];
    logic signed [31:0] r6_vel [3];
    logic signed [32:0] r7_v   [3];
    logic [2:0]         r7_cond;

    logic [26:0]        n5_qf [3];
    logic [26:0]        n5_qw [3];
    logic signed [31:0] n6_vel [3];
    logic [28:0]        n6_wsum;
    logic signed [32:0] n7_v  [3];
    logic [2:0]         n7_cond;

    for (genvar a = 0; a < 3; a++) begin : g_ax
        logic [31:0]        rf;
        logic [31:0]        rw;
        logic signed [41:0] pred;

        // one correction step after the reciprocal multiply
        assign rf = {1'b0, r4_xf[a]} - 32'(r4_qf[a]) * 32'd125;
        assign rw = {1'b0, r4_xw[a]} - 32'(r4_qw[a]) * 32'd25;
        assign n5_qf[a] = (rf >= 32'd125) ? r4_qf[a] + 27'd1 : r4_qf[a];
        assign n5_qw[a] = (rw >= 32'd25)  ? r4_qw[a] + 27'd1 : r4_qw[a];

        assign n6_vel[a] = sat_s32(48'(r5_vel[a]) + 48'($signed({21'd0, r5_qf[a]}))
                                   - FORCE_UNBIAS);

        assign pred = 42'($signed(r_cy[6].pos[a])) + 42'(r6_vel[a]) * 42'sd35;
        assign n7_cond[a] = (pred < 42'sd0) || (pred >= lim);
        assign n7_v[a]    = 33'(r6_vel[a]);

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r2_xf[a]  <= n2_xf[a];
                r2_xw[a]  <= n2_xw[a];
                r2_vel[a] <= s1_vel[a];
                r3_pf[a]  <= 57'(r2_xf[a]) * 57'(R125);
                r3_pw[a]  <= 59'(r2_xw[a]) * 59'(R25);
                r3_xf[a]  <= r2_xf[a];
                r3_xw[a]  <= r2_xw[a];
                r3_vel[a] <= r2_vel[a];
                r4_qf[a]  <= r3_pf[a][56:30] >> 2;
                r4_qw[a]  <= r3_pw[a][58:32];
                r4_xf[a]  <= r3_xf[a];
                r4_xw[a]  <= r3_xw[a];
                r4_vel[a] <= r3_vel[a];
                r5_qf[a]  <= n5_qf[a];
                r5_qw[a]  <= n5_qw[a];
                r5_vel[a] <= r4_vel[a];
                r6_vel[a] <= n6_vel[a];
                r7_v[a]   <= n7_v[a];
            end
        end
    end

    // wall density terms stay far below the 31-bit ceiling
    assign n6_wsum = 29'(r5_qw[0]) + 29'(r5_qw[1]) + 29'(r5_qw[2]);

    t_carry n2_cy;
    t_carry n6_cy;

    always_comb begin
        n2_cy.pos  = {s1_pos[2], s1_pos[1], s1_pos[0]};
        n2_cy.wf   = {n2_wf[2], n2_wf[1], n2_wf[0]};
        n2_cy.wden = '0;
        n2_cy.pres = n2_pres;
    end

    always_comb begin
        n6_cy      = r_cy[5];
        n6_cy.wden = 31'(n6_wsum);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_cy[2] <= n2_cy;
            for (int s = 3; s <= 16; s++) begin
                if (s == 6) begin
                    r_cy[s] <= n6_cy;
                end else begin
                    r_cy[s] <= r_cy[s-1];
                end
            end
            r7_cond <= n7_cond;
        end
    end

    // bounce steps: three stages each, axis x then y then z
    logic [62:0]        r_a_prod [3][3];
    logic [31:0]        r_a_u    [3][3];
    logic               r_a_neg  [3][3];
    logic signed [32:0] r_a_v    [3][3];
    logic [2:0]         r_a_cond [3];
    logic [29:0]        r_b_qu   [3][3];
    logic [2:0]         r_b_ru   [3][3];
    logic               r_b_neg  [3][3];
    logic signed [32:0] r_b_v    [3][3];
    logic [2:0]         r_b_cond [3];
    logic signed [32:0] r_c_v    [3][3];
    logic [2:0]         r_c_cond [3];

    for (genvar k = 0; k < 3; k++) begin : g_bn
        logic [2:0] cond_in;

        if (k == 0) begin : g_first
            assign cond_in = r7_cond;
        end else begin : g_next
            assign cond_in = r_c_cond[k-1];
        end

        for (genvar a = 0; a < 3; a++) begin : g_ax
            logic signed [32:0] v_in;
            logic signed [32:0] w;
            logic [31:0]        u;
            logic [29:0]        qu0;
            logic [31:0]        ru0;
            logic [29:0]        qu;
            logic [2:0]         ru;
            logic signed [32:0] q;
            logic [2:0]         rr;
            logic signed [32:0] res;

            if (k == 0) begin : g_first
                assign v_in = r7_v[a];
            end else begin : g_next
                assign v_in = r_c_v[k-1][a];
            end

            assign w   = (a == k && cond_in[k]) ? -v_in : v_in;
            assign u   = w[32] ? 32'(-w) : 32'(w);

            assign qu0 = r_a_prod[k][a][62:33];
            assign ru0 = r_a_u[k][a] - 32'(qu0) * 32'd5;
            assign qu  = (ru0 >= 32'd5) ? qu0 + 30'd1 : qu0;
            assign ru  = (ru0 >= 32'd5) ? 3'(ru0 - 32'd5) : ru0[2:0];

            // floor division of the signed value by five
            always_comb begin
                if (r_b_neg[k][a] && r_b_ru[k][a] != 3'd0) begin
                    q  = -33'($signed({3'd0, r_b_qu[k][a]})) - 33'sd1;
                    rr = 3'd5 - r_b_ru[k][a];
                end else if (r_b_neg[k][a]) begin
                    q  = -33'($signed({3'd0, r_b_qu[k][a]}));
                    rr = 3'd0;
                end else begin
                    q  = 33'($signed({3'd0, r_b_qu[k][a]}));
                    rr = r_b_ru[k][a];
                end
            end

            assign res = (q <<< 2) + 33'($signed({1'b0, rnd_q5(rr)}));

            always_ff @(posedge i_clk) begin
                if (pipe_en) begin
                    r_a_prod[k][a] <= 63'(u) * 63'(R5);
                    r_a_u[k][a]    <= u;
                    r_a_neg[k][a]  <= w[32];
                    r_a_v[k][a]    <= v_in;
                    r_b_qu[k][a]   <= qu;
                    r_b_ru[k][a]   <= ru;
                    r_b_neg[k][a]  <= r_a_neg[k][a];
                    r_b_v[k][a]    <= r_a_v[k][a];
                    r_c_v[k][a]    <= r_b_cond[k][k] ? res : r_b_v[k][a];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_a_cond[k] <= cond_in;
                r_b_cond[k] <= r_a_cond[k];
                r_c_cond[k] <= r_b_cond[k];
            end
        end
    end

    // stage 17: final advance
    t_main n17;
    t_main r_m17;
    t_main r_dly [DLY];

    for (genvar a = 0; a < 3; a++) begin : g_fin
        logic signed [31:0] vs;

        assign vs          = sat_s32(48'(r_c_v[2][a]));
        assign n17.nvel[a] = vs;
        assign n17.npos[a] = sat_s32(48'($signed(r_cy[16].pos[a]))
                                     + 48'(vs) * VEL_TO_POS);
        assign n17.wf[a]   = r_cy[16].wf[a];
    end

    assign n17.wden = r_cy[16].wden;
    assign n17.pres = r_cy[16].pres;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_m17    <= n17;
            r_dly[0] <= r_m17;
            for (int s = 1; s < DLY; s++) begin
                r_dly[s] <= r_dly[s-1];
            end
        end
    end

    assign o_out_data.new_pos_x    = r_dly[DLY-1].npos[0];
    assign o_out_data.new_pos_y    = r_dly[DLY-1].npos[1];
    assign o_out_data.new_pos_z    = r_dly[DLY-1].npos[2];
    assign o_out_data.new_vel_x    = r_dly[DLY-1].nvel[0];
    assign o_out_data.new_vel_y    = r_dly[DLY-1].nvel[1];
    assign o_out_data.new_vel_z    = r_dly[DLY-1].nvel[2];
    assign o_out_data.wall_force_x = r_dly[DLY-1].wf[0];
    assign o_out_data.wall_force_y = r_dly[DLY-1].wf[1];
    assign o_out_data.wall_force_z = r_dly[DLY-1].wf[2];
    assign o_out_data.wall_density = r_dly[DLY-1].wden;
    assign o_out_data.pressure     = r_dly[DLY-1].pres;

endmodule

`default_nettype wire

// ===== sv/pwb_chk.sv =====
// ----------------------------------------------------------------------------
// pwb_chk: port-level checks
// Watches the handshake and configuration ports of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pwb_chk (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_stall,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire pwb_pkg::t_out i_out_data,
    input  wire logic          i_cfg_ready
);

    // input side only backs up when a finished result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> (i_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result dropped or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind particle_integrate_wall_bounce pwb_chk u_pwb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data),
    .i_cfg_ready (o_cfg_ready)
);

`default_nettype wire

// ===== bench/tb_particle_integrate_wall_bounce.sv =====
// ----------------------------------------------------------------------------
// tb_particle_integrate_wall_bounce: particle update pipeline testbench
// Drives particles through the block under random flow control, predicts each
// result with a behavioral model of the integration step and checks in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_particle_integrate_wall_bounce;
    timeunit 1ns;
    timeprecision 1ps;
    import pwb_pkg::*;

    localparam int ONE        = 65536;
    localparam int LATENCY    = 48;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 2000;

    // --------------------------------------------------------------------
    // expected-result store and particle step predictor
    // --------------------------------------------------------------------
    class particle_scoreboard;
        longint box_lim;
        longint mass;
        longint pres_ofs;
        t_out   pending[$];
        int     errors;

        function new();
            box_lim  = 100;
            mass     = 65536;
            pres_ofs = 0;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_BOX_LIMIT: box_lim = longint'(val[14:0]);
                CFG_MASS:      mass = longint'(val[30:0]);
                CFG_PRES_OFS:  pres_ofs = longint'(signed'(val));
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0) q = q - 1;
            return q;
        endfunction

        function void note_particle(t_in p);
            longint lim, hi, dens, wden, f, depth;
            longint pos[3], vel[3], wf[3], pred[3];
            t_out r;
            lim  = box_lim * ONE;
            hi   = lim - ONE;
            dens = longint'(p.density_sum) + ONE;
            wden = 0;
            pos[0] = p.pos_x;   pos[1] = p.pos_y;   pos[2] = p.pos_z;
            vel[0] = p.vel_x;   vel[1] = p.vel_y;   vel[2] = p.vel_z;
            for (int i = 0; i < 3; i++) begin
                f = (i == 0) ? longint'(p.force_x) :
                    (i == 1) ? longint'(p.force_y) : longint'(p.force_z);
                vel[i] = sat32(vel[i] + fdiv(2 * f + 1000, 2000));
                wf[i] = 0;
                if (pos[i] < ONE) begin
                    depth = ONE - pos[i];
                    wf[i] = sat32(depth);
                    wden += (depth + 50) / 100;
                end else if (pos[i] > hi) begin
                    depth = pos[i] - hi;
                    wf[i] = sat32(-depth);
                    wden += (depth + 50) / 100;
                end
            end
            if (wden > 64'sd2147483647) wden = 64'sd2147483647;
            for (int i = 0; i < 3; i++) pred[i] = pos[i] + vel[i] * 35;
            // bounce: flip the offending axis, then damp the whole vector
            for (int i = 0; i < 3; i++) begin
                if (pred[i] < 0 || pred[i] >= lim) begin
                    vel[i] = -vel[i];
                    for (int j = 0; j < 3; j++) vel[j] = fdiv(vel[j] * 8 + 5, 10);
                end
            end
            for (int i = 0; i < 3; i++) vel[i] = sat32(vel[i]);
            r.new_pos_x = 32'(sat32(pos[0] + vel[0] * 35));
            r.new_pos_y = 32'(sat32(pos[1] + vel[1] * 35));
            r.new_pos_z = 32'(sat32(pos[2] + vel[2] * 35));
            r.new_vel_x = 32'(vel[0]);
            r.new_vel_y = 32'(vel[1]);
            r.new_vel_z = 32'(vel[2]);
            r.wall_force_x = 32'(wf[0]);
            r.wall_force_y = 32'(wf[1]);
            r.wall_force_z = 32'(wf[2]);
            r.wall_density = 31'(wden);
            r.pressure = 32'(sat32(pres_ofs + (dens >>> 1)));
            r.mass_over_density = 31'((mass * ONE) / dens);
            pending.push_back(r);
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out a);
            t_out e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("new_pos_x", e.new_pos_x, a.new_pos_x);
            cmp("new_pos_y", e.new_pos_y, a.new_pos_y);
            cmp("new_pos_z", e.new_pos_z, a.new_pos_z);
            cmp("new_vel_x", e.new_vel_x, a.new_vel_x);
            cmp("new_vel_y", e.new_vel_y, a.new_vel_y);
            cmp("new_vel_z", e.new_vel_z, a.new_vel_z);
            cmp("wall_force_x", e.wall_force_x, a.wall_force_x);
            cmp("wall_force_y", e.wall_force_y, a.wall_force_y);
            cmp("wall_force_z", e.wall_force_z, a.wall_force_z);
            cmp("wall_density", e.wall_density, a.wall_density);
            cmp("pressure", e.pressure, a.pressure);
            cmp("mass_over_density", e.mass_over_density, a.mass_over_density);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_data = '0;
    logic        in_stall;
    logic        out_valid;
    t_out        out_data;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BOX_LIMIT;
    logic [31:0] cfg_data = '0;

    particle_scoreboard sb = new();
    bit  calm_mode = 1'b0;     // no random gaps on either side
    bit  hold_sink = 1'b0;     // long receiver hold-off
    int  idle_cycles = 0;

    always #5 clk = ~clk;

    particle_integrate_wall_bounce u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // receiver: check transfers, stall at random
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
        if (hold_sink) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm_mode && ($urandom_range(99) < 9);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_particle(t_in p);
        while (!calm_mode && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_particle(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(longint lim);
        longint v;
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($urandom_range(2 * ONE) - ONE);
            2: begin
                v = lim * ONE - ONE + $urandom_range(2 * ONE) - ONE;
                return 32'(v);
            end
            default: return 32'($urandom_range(32'(lim * ONE)));
        endcase
    endfunction

    function automatic logic [31:0] rand_small(int span);
        if ($urandom_range(7) == 0) return $urandom();
        return 32'($urandom_range(2 * span) - span);
    endfunction

    function automatic t_in rand_particle(longint lim);
        t_in p;
        p.pos_x = rand_coord(lim);
        p.pos_y = rand_coord(lim);
        p.pos_z = rand_coord(lim);
        p.vel_x = rand_small(4 * ONE);
        p.vel_y = rand_small(4 * ONE);
        p.vel_z = rand_small(4 * ONE);
        p.force_x = rand_small(2000 * ONE);
        p.force_y = rand_small(2000 * ONE);
        p.force_z = rand_small(2000 * ONE);
        p.density_sum = ($urandom_range(3) == 0) ? 31'($urandom()) :
                                                   31'($urandom_range(20 * ONE));
        return p;
    endfunction

    initial begin
        t_in p;
        logic [31:0] lims[4];
        logic [31:0] masses[4];
        logic [31:0] ofs[4];
        lims   = '{32'd100, 32'd2, 32'd32767, 32'd17};
        masses = '{32'd65536, 32'd0, 32'h7FFF_FFFF, 32'd12345};
        ofs    = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, walls on both sides, bounces
        calm_mode = 1'b1;
        for (int k = 0; k < 20; k++) begin
            p = rand_particle(100);
            case (k)
                0: p = '0;
                1: p = '{default: 32'sh7FFF_FFFF, density_sum: 31'h7FFF_FFFF};
                2: p = '{default: 32'sh8000_0000, density_sum: 31'd0};
                3: begin
                    p.pos_x = 32'sd0; p.pos_y = 32'sd100 * ONE; p.pos_z = ONE;
                end
                4: begin
                    p.pos_x = 50 * ONE; p.vel_x = 2 * ONE;
                    p.pos_y = 50 * ONE; p.vel_y = -2 * ONE;
                    p.pos_z = 50 * ONE; p.vel_z = 0;
                end
                5: begin
                    p.force_x = 32'sd500; p.force_y = -32'sd500; p.force_z = 32'sd1500;
                end
                6: p.density_sum = 31'h7FFF_FFFF;
                default: ;
            endcase
            send_particle(p);
        end
        drain();
        calm_mode = 1'b0;

        // random phases across register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_BOX_LIMIT, lims[ph]);
            write_reg(CFG_MASS, masses[ph]);
            write_reg(CFG_PRES_OFS, ofs[ph]);
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                calm_mode = (k >= 100 && k < 200);
                if (ph == 1 && k == 250) begin
                    fork
                        begin
                            hold_sink = 1'b1;
                            repeat (150) @(posedge clk);
                            hold_sink = 1'b0;
                        end
                    join_none
                end
                send_particle(rand_particle(sb.box_lim));
            end
            calm_mode = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
